// ===== hw/rtl/magnetoelastic_field_cubic_core_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the magnetoelastic field core
// Clocked, reset-qualified and unqualified concurrent assertion forms.
// ----------------------------------------------------------------------------
`ifndef MAGNETOELASTIC_FIELD_CUBIC_CORE_ASSERT_SVH
`define MAGNETOELASTIC_FIELD_CUBIC_CORE_ASSERT_SVH

// Property checked only while out of reset
`define MEFC_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("mefc assertion failed");

// Property checked at every edge, reset included
`define MEFC_ASSERT_ALWAYS(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("mefc assertion failed");

`endif

// ===== hw/rtl/mefc_pkg.sv =====
// ----------------------------------------------------------------------------
// mefc_pkg
// Shared types, register indexes and constants of the magnetoelastic core.
// ----------------------------------------------------------------------------
package mefc_pkg;

	// Configuration register indexes
	localparam logic [2:0] REG_AXIS_ONE = 3'd0;
	localparam logic [2:0] REG_AXIS_TWO = 3'd1;
	localparam logic [2:0] REG_INV_SAT  = 3'd2;
	localparam logic [2:0] REG_COEF_D   = 3'd3;
	localparam logic [2:0] REG_COEF_S   = 3'd4;

	// Vacuum permeability, Q.40
	localparam logic [20:0] MU0_Q40 = 21'd1381687;
	// Clamp on the mean magnitude
	localparam logic [63:0] MAG_MAX = 64'h0003_FFFF_FFFF_FFFF;

	typedef struct packed {
		logic valid;
		logic empty;
		logic last;
	} ctl_t;

	// Axes indexed [axis][component], plus scaling coefficients
	typedef struct packed {
		logic [2:0][2:0][15:0] e;
		logic [31:0]           inv;
		logic signed [31:0]    cd;
		logic signed [31:0]    cs;
	} cfg_t;

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		logic signed [31:0] r;
		if (v > 64'sd2147483647) r = 32'sh7FFF_FFFF;
		else if (v < -64'sd2147483648) r = 32'sh8000_0000;
		else r = v[31:0];
		return r;
	endfunction

endpackage

// ===== hw/rtl/mefc_axis.sv =====
// ----------------------------------------------------------------------------
// mefc_axis
// Configuration registers and the registered third cubic axis e3 = e1 x e2.
// ----------------------------------------------------------------------------
module mefc_axis (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_we,
	input  logic [2:0]      cfg_index,
	input  logic [47:0]     cfg_data,
	output mefc_pkg::cfg_t  cfg
);
	import mefc_pkg::*;

	logic [47:0]        axis_one_q;
	logic [47:0]        axis_two_q;
	logic [31:0]        inv_q;
	logic signed [31:0] cd_q;
	logic signed [31:0] cs_q;
	logic [47:0]        axis_three_q;
	logic [47:0]        e3_next;

	// Rounded, clamped cross term a*b - c*d at Q.14
	function automatic logic [15:0] cross_term(input logic signed [15:0] a,
		input logic signed [15:0] b, input logic signed [15:0] c,
		input logic signed [15:0] d);
		logic signed [33:0] t;
		logic signed [19:0] r;
		logic [15:0]        o;
		t = a * b - c * d + 34'sd8192;
		r = $signed(t[33:14]);
		if (r > 20'sd32767) o = 16'h7FFF;
		else if (r < -20'sd32768) o = 16'h8000;
		else o = r[15:0];
		return o;
	endfunction

	// Form the third axis from the stored two
	always_comb begin
		e3_next[15:0]  = cross_term($signed(axis_one_q[31:16]), $signed(axis_two_q[47:32]),
			$signed(axis_one_q[47:32]), $signed(axis_two_q[31:16]));
		e3_next[31:16] = cross_term($signed(axis_one_q[47:32]), $signed(axis_two_q[15:0]),
			$signed(axis_one_q[15:0]), $signed(axis_two_q[47:32]));
		e3_next[47:32] = cross_term($signed(axis_one_q[15:0]), $signed(axis_two_q[31:16]),
			$signed(axis_one_q[31:16]), $signed(axis_two_q[15:0]));
	end

	// Take register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			axis_one_q   <= 48'd16384;
			axis_two_q   <= 48'd1073741824;
			inv_q        <= '0;
			cd_q         <= '0;
			cs_q         <= '0;
			axis_three_q <= 48'h4000_0000_0000;
		end else begin
			axis_three_q <= e3_next;
			if (cfg_we) begin
				case (cfg_index)
					REG_AXIS_ONE: axis_one_q <= cfg_data;
					REG_AXIS_TWO: axis_two_q <= cfg_data;
					REG_INV_SAT:  inv_q <= cfg_data[31:0];
					REG_COEF_D:   cd_q <= $signed(cfg_data[31:0]);
					REG_COEF_S:   cs_q <= $signed(cfg_data[31:0]);
					default: ;
				endcase
			end
		end
	end

	// Publish axes per component
	always_comb begin
		for (int c = 0; c < 3; c++) begin
			cfg.e[0][c] = axis_one_q[16*c +: 16];
			cfg.e[1][c] = axis_two_q[16*c +: 16];
			cfg.e[2][c] = axis_three_q[16*c +: 16];
		end
		cfg.inv = inv_q;
		cfg.cd  = cd_q;
		cfg.cs  = cs_q;
	end

endmodule

// ===== hw/rtl/mefc_field.sv =====
// ----------------------------------------------------------------------------
// mefc_field
// Seven-stage field pipeline: rotation into crystal axes, B1 and B2 terms,
// field per cell and the M.H products for the energy tail.
// ----------------------------------------------------------------------------
module mefc_field (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               adv,
	input  mefc_pkg::cfg_t     cfg,
	input  logic               in_valid,
	input  logic [263:0]       in_data,
	input  logic               in_empty,
	input  logic               in_last,
	output mefc_pkg::ctl_t     ctl_s7,
	output logic signed [31:0] fld_s7 [3],
	output logic signed [55:0] dotp_s7 [3]
);
	import mefc_pkg::*;

	logic signed [15:0] e [3][3];

	ctl_t ctl_s1, ctl_s2, ctl_s3, ctl_s4, ctl_s5, ctl_s6;

	logic signed [23:0] mg_s1 [3], mg_s2 [3], mg_s3 [3], mg_s4 [3], mg_s5 [3], mg_s6 [3];
	logic signed [31:0] sd_s1 [3], so_s1 [3];
	logic signed [39:0] pmd_s2 [3][3];
	logic signed [47:0] psd_s2 [3][3], pso_s2 [3][3];
	logic signed [60:0] mi_s3 [3];
	logic signed [31:0] rd_s3 [3], ro_s3 [3], ro_s4 [3];
	logic signed [63:0] mr_s4 [3];
	logic signed [47:0] em_s4 [3][3][3];
	logic signed [50:0] b1p_s5 [3][3];
	logic signed [63:0] q_s5 [3][3];
	logic signed [63:0] d_s6 [3], h_s6 [3];

	logic signed [27:0] md [3];
	logic signed [31:0] rd [3], ro [3], m [3];
	logic signed [34:0] t [3];
	logic signed [31:0] pz [3], py [3], px [3];
	logic signed [31:0] b1 [3], b2 [3];
	logic signed [31:0] fld [3];

	// Unpack axes
	always_comb begin
		for (int a = 0; a < 3; a++)
			for (int c = 0; c < 3; c++)
				e[a][c] = $signed(cfg.e[a][c]);
	end

	// Rotated magnetization and strains, rounded to Q.14 steps
	always_comb begin
		logic signed [41:0] smd;
		logic signed [49:0] ssd, sso;
		for (int a = 0; a < 3; a++) begin
			smd = pmd_s2[a][0] + pmd_s2[a][1] + pmd_s2[a][2] + 42'sd8192;
			md[a] = $signed(smd[41:14]);
			ssd = psd_s2[a][0] + psd_s2[a][1] + psd_s2[a][2] + 50'sd8192;
			sso = pso_s2[a][0] + pso_s2[a][1] + pso_s2[a][2] + 50'sd8192;
			rd[a] = sat32($signed(ssd[49:14]));
			ro[a] = sat32($signed(sso[49:14]));
		end
	end

	// Normalized magnetization m = M/Ms
	always_comb begin
		logic signed [61:0] r;
		for (int a = 0; a < 3; a++) begin
			r = mi_s3[a] + 62'sd2097152;
			m[a] = sat32($signed(r[61:22]));
		end
	end

	// B1 partial terms and B2 pair sums
	always_comb begin
		logic signed [64:0] r;
		logic signed [49:0] sz, sy, sx;
		for (int a = 0; a < 3; a++) begin
			r = mr_s4[a] + 65'sd536870912;
			t[a] = $signed(r[64:30]);
		end
		for (int c = 0; c < 3; c++) begin
			sz = em_s4[0][c][1] + em_s4[1][c][0] + 50'sd8192;
			sy = em_s4[0][c][2] + em_s4[2][c][0] + 50'sd8192;
			sx = em_s4[1][c][2] + em_s4[2][c][1] + 50'sd8192;
			pz[c] = sat32($signed(sz[49:14]));
			py[c] = sat32($signed(sy[49:14]));
			px[c] = sat32($signed(sx[49:14]));
		end
	end

	// Bracket sums of B1 and B2
	always_comb begin
		logic signed [53:0] s1;
		logic signed [64:0] r0, r1, r2;
		logic signed [36:0] s2;
		for (int c = 0; c < 3; c++) begin
			s1 = b1p_s5[0][c] + b1p_s5[1][c] + b1p_s5[2][c] + 54'sd8192;
			b1[c] = sat32($signed(s1[53:14]));
			r0 = q_s5[c][0] + 65'sd536870912;
			r1 = q_s5[c][1] + 65'sd536870912;
			r2 = q_s5[c][2] + 65'sd536870912;
			s2 = $signed(r0[64:30]) + $signed(r1[64:30]) + $signed(r2[64:30]);
			b2[c] = sat32(s2);
		end
	end

	// Field per component, zero for an empty cell
	always_comb begin
		logic signed [64:0] rd1, rh1;
		logic signed [27:0] f;
		for (int c = 0; c < 3; c++) begin
			rd1 = d_s6[c] + 65'sd137438953472;
			rh1 = h_s6[c] + 65'sd137438953472;
			f = $signed(rd1[64:38]) + $signed(rh1[64:38]);
			fld[c] = ctl_s6.empty ? 32'sd0 : 32'(f);
		end
	end

	// Advance valid, empty and last bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
			ctl_s4 <= '0;
			ctl_s5 <= '0;
			ctl_s6 <= '0;
			ctl_s7 <= '0;
		end else if (adv) begin
			ctl_s1 <= '{valid: in_valid, empty: in_empty, last: in_last};
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
			ctl_s4 <= ctl_s3;
			ctl_s5 <= ctl_s4;
			ctl_s6 <= ctl_s5;
			ctl_s7 <= ctl_s6;
		end
	end

	// Advance payload
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int c = 0; c < 3; c++) begin
				mg_s1[c] <= $signed(in_data[24*c +: 24]);
				sd_s1[c] <= $signed(in_data[72 + 32*c +: 32]);
				so_s1[c] <= $signed(in_data[168 + 32*c +: 32]);
			end
			for (int a = 0; a < 3; a++) begin
				for (int c = 0; c < 3; c++) begin
					pmd_s2[a][c] <= mg_s1[c] * e[a][c];
					psd_s2[a][c] <= sd_s1[c] * e[a][c];
					pso_s2[a][c] <= so_s1[c] * e[a][c];
					b1p_s5[a][c] <= t[a] * e[a][c];
					for (int j = 0; j < 3; j++)
						em_s4[a][c][j] <= e[a][c] * m[j];
				end
				mi_s3[a] <= md[a] * $signed({1'b0, cfg.inv});
				rd_s3[a] <= rd[a];
				ro_s3[a] <= ro[a];
				mr_s4[a] <= m[a] * rd_s3[a];
				ro_s4[a] <= ro_s3[a];
			end
			for (int c = 0; c < 3; c++) begin
				q_s5[c][0] <= ro_s4[2] * pz[c];
				q_s5[c][1] <= ro_s4[1] * py[c];
				q_s5[c][2] <= ro_s4[0] * px[c];
				d_s6[c]    <= b1[c] * cfg.cd;
				h_s6[c]    <= b2[c] * cfg.cs;
				fld_s7[c]  <= fld[c];
				dotp_s7[c] <= mg_s6[c] * fld[c];
				mg_s2[c] <= mg_s1[c];
				mg_s3[c] <= mg_s2[c];
				mg_s4[c] <= mg_s3[c];
				mg_s5[c] <= mg_s4[c];
				mg_s6[c] <= mg_s5[c];
			end
		end
	end

endmodule

// ===== hw/rtl/mefc_energy.sv =====
// ----------------------------------------------------------------------------
// mefc_energy
// Energy accumulator, cell counter, bit-serial mean divider and the
// output register.
// ----------------------------------------------------------------------------
module mefc_energy #(
	parameter int MAX_CELLS = 1048576
) (
	input  logic               clk,
	input  logic               arst_n,
	input  mefc_pkg::ctl_t     ctl_s7,
	input  logic signed [31:0] fld_s7 [3],
	input  logic signed [55:0] dotp_s7 [3],
	input  logic               m_tready,
	output logic               adv,
	output logic               m_tvalid,
	output logic [159:0]       m_tdata,
	output logic               m_tlast
);
	import mefc_pkg::*;

	localparam int CW = $clog2(MAX_CELLS + 1);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_MUL  = 2'd2;
	localparam logic [1:0] ST_FIN  = 2'd3;

	logic [1:0]         state_q;
	logic [5:0]         cnt_q;
	logic               out_valid_q;
	logic signed [63:0] sum_q;
	logic [CW-1:0]      count_q;

	logic [63:0]        quo_q;
	logic [CW-1:0]      rem_q;
	logic [CW-1:0]      den_q;
	logic               pos_q;
	logic [45:0]        pa_q, pb_q;
	logic signed [31:0] fld_q [3];
	logic signed [63:0] energy_q;
	logic               last_q;

	logic signed [57:0] dot;
	logic signed [64:0] wide_sum;
	logic signed [63:0] new_sum;
	logic [CW-1:0]      new_count;
	logic [63:0]        mag;
	logic               take, start_div;
	logic [CW:0]        trial, diff;
	logic               ge;
	logic [49:0]        magc;
	logic [46:0]        inner_w, res_w;

	// Stall the whole pipeline while the mean is divided and scaled, or while the result waits
	assign adv       = (state_q == ST_IDLE) && (!out_valid_q || m_tready);
	assign take      = adv && ctl_s7.valid;
	assign start_div = ctl_s7.last && (new_count != '0);

	// Saturating sum and capped count
	always_comb begin
		dot = dotp_s7[0] + dotp_s7[1] + dotp_s7[2];
		wide_sum = sum_q + dot;
		if (wide_sum[64] != wide_sum[63])
			new_sum = wide_sum[64] ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
		else
			new_sum = wide_sum[63:0];
		if (ctl_s7.empty) begin
			new_sum   = sum_q;
			new_count = count_q;
		end else begin
			new_count = (count_q < CW'(MAX_CELLS)) ? CW'(count_q + 1'b1) : count_q;
		end
		mag = new_sum[63] ? 64'(-new_sum) : new_sum;
	end

	// One restoring division step, and the energy scaling
	always_comb begin
		trial   = {rem_q, quo_q[63]};
		ge      = trial >= {1'b0, den_q};
		diff    = trial - {1'b0, den_q};
		magc    = (quo_q > MAG_MAX) ? MAG_MAX[49:0] : quo_q[49:0];
		inner_w = {1'b0, pb_q} + 47'h1_0000_0000;
		res_w   = {1'b0, pa_q} + 47'(inner_w[46:25]);
	end

	// Control: accumulator, output valid, divider sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
			sum_q       <= '0;
			count_q     <= '0;
		end else begin
			if (take) begin
				if (ctl_s7.last) begin
					sum_q   <= '0;
					count_q <= '0;
				end else begin
					sum_q   <= new_sum;
					count_q <= new_count;
				end
				if (start_div) begin
					state_q     <= ST_DIV;
					cnt_q       <= '1;
					out_valid_q <= 1'b0;
				end else begin
					out_valid_q <= 1'b1;
				end
			end else if (m_tready && state_q == ST_IDLE) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_DIV: begin
					cnt_q <= 6'(cnt_q - 6'd1);
					if (cnt_q == '0) state_q <= ST_MUL;
				end
				ST_MUL: state_q <= ST_FIN;
				ST_FIN: begin
					state_q     <= ST_IDLE;
					out_valid_q <= 1'b1;
				end
				default: ;
			endcase
		end
	end

	// Payload: output fields and divider datapath
	always_ff @(posedge clk) begin
		if (take) begin
			for (int c = 0; c < 3; c++) fld_q[c] <= fld_s7[c];
			last_q   <= ctl_s7.last;
			energy_q <= '0;
			quo_q    <= mag;
			den_q    <= new_count;
			rem_q    <= '0;
			pos_q    <= new_sum > 64'sd0;
		end
		case (state_q)
			ST_DIV: begin
				rem_q <= ge ? diff[CW-1:0] : trial[CW-1:0];
				quo_q <= {quo_q[62:0], ge};
			end
			ST_MUL: begin
				pa_q <= magc[49:25] * MU0_Q40;
				pb_q <= magc[24:0] * MU0_Q40;
			end
			ST_FIN: energy_q <= pos_q ? -64'(res_w[46:8]) : 64'(res_w[46:8]);
			default: ;
		endcase
	end

	assign m_tvalid = out_valid_q;
	assign m_tlast  = last_q;
	assign m_tdata  = {energy_q, fld_q[2], fld_q[1], fld_q[0]};

endmodule

// ===== hw/rtl/magnetoelastic_field_cubic_core.sv =====
// ----------------------------------------------------------------------------
// magnetoelastic_field_cubic_core
// Cubic magnetoelastic effective field per mesh cell, with mean energy
// density reported on the last cell of each sweep.
// ----------------------------------------------------------------------------
// One cell per cycle while no result waits and no division runs.
// On the last cell of a sweep with a non-zero cell count, the mean runs
// through a 64-step bit-serial divider, then a multiply and a final scaling
// state, and the pipeline holds during that time.
// Reset (arst_n low) clears all valid bits, the sum and count, and loads the
// default axes with zero coefficients.
module magnetoelastic_field_cubic_core #(
	parameter int MAX_CELLS = 1048576
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic [2:0]    cfg_index,
	input  logic [47:0]   cfg_data,
	input  logic          s_tvalid,
	output logic          s_tready,
	// mag_x, mag_y, mag_z, strain_xx, strain_yy, strain_zz,
	// strain_yz, strain_xz, strain_xy
	input  logic [263:0]  s_tdata,
	input  logic          s_tlast,
	// cell_empty
	input  logic          s_tuser,
	output logic          m_tvalid,
	input  logic          m_tready,
	// field_x, field_y, field_z, energy_density
	output logic [159:0]  m_tdata,
	output logic          m_tlast
);
	import mefc_pkg::*;

	cfg_t               cfg;
	ctl_t               ctl_s7;
	logic signed [31:0] fld_s7 [3];
	logic signed [55:0] dotp_s7 [3];
	logic               adv;

	assign s_tready = adv;

	mefc_axis u_axis (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	mefc_field u_field (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.cfg      (cfg),
		.in_valid (s_tvalid),
		.in_data  (s_tdata),
		.in_empty (s_tuser),
		.in_last  (s_tlast),
		.ctl_s7   (ctl_s7),
		.fld_s7   (fld_s7),
		.dotp_s7  (dotp_s7)
	);

	mefc_energy #(.MAX_CELLS(MAX_CELLS)) u_energy (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl_s7   (ctl_s7),
		.fld_s7   (fld_s7),
		.dotp_s7  (dotp_s7),
		.m_tready (m_tready),
		.adv      (adv),
		.m_tvalid (m_tvalid),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule

// ===== hw/rtl/mefc_checker.sv =====
// ----------------------------------------------------------------------------
// mefc_checker
// Port-level checks on the result stream, bound to the top level.
// ----------------------------------------------------------------------------
`include "magnetoelastic_field_cubic_core_assert.svh"

module mefc_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [159:0] m_tdata,
	input logic         m_tlast
);
	// Hold a stalled result
	`MEFC_ASSERT(a_valid_holds, clk, arst_n, m_tvalid && !m_tready |=> m_tvalid)
	`MEFC_ASSERT(a_data_holds, clk, arst_n, m_tvalid && !m_tready |=> $stable(m_tdata))
	// Energy only on the sweep end
	`MEFC_ASSERT(a_energy_zero, clk, arst_n, m_tvalid && !m_tlast |-> m_tdata[159:96] == 64'd0)
	// No result shown during reset
	`MEFC_ASSERT_ALWAYS(a_reset_idle, clk, !arst_n |-> !m_tvalid)
endmodule

bind magnetoelastic_field_cubic_core mefc_checker u_mefc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);
